// File: hdl/boot_image_transfer_host_fsm_unit_defines.svh
// assertion macros for the boot image transfer host
`ifndef BOOT_IMAGE_TRANSFER_HOST_FSM_UNIT_DEFINES_SVH
`define BOOT_IMAGE_TRANSFER_HOST_FSM_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

`define BITFH_ASSERT_IMPL(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("bitfh assertion failed");

`define BITFH_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("bitfh assertion failed");

`else

`define BITFH_ASSERT_IMPL(label, clk, rst, cond, prop)

`define BITFH_ASSERT_NEXT(label, clk, rst, cond, prop)

`endif

`endif

// File: hdl/bitfh_pkg.sv
package bitfh_pkg;

   localparam int unsigned MAX_FRAME_BYTES = 1048576;
   localparam int unsigned CAPTURE_BYTES   = 24;
   localparam int unsigned HEADER_BYTES    = 8;
   localparam int unsigned HDR_COUNT_W     = 4;
   localparam int unsigned SEEN_W          = $clog2(MAX_FRAME_BYTES) + 1;
   localparam int unsigned CAP_IDX_W       = $clog2(CAPTURE_BYTES);
   localparam int unsigned IMAGE_SIZE_W    = 31;
   localparam int unsigned CSR_INDEX_W     = 2;
   localparam int unsigned QUEUE_DEPTH     = 2;
   localparam int unsigned QPTR_W          = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W          = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_SIZE    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HELLO_TIMEOUT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DATA_TIMEOUT  = 2'd2;

   localparam logic [31:0] CMD_HELLO_REQ    = 32'h0000_0001;
   localparam logic [31:0] CMD_READ_DATA    = 32'h0000_0003;
   localparam logic [31:0] CMD_END_IMAGE    = 32'h0000_0004;
   localparam logic [31:0] CMD_DONE_RSP     = 32'h0000_0006;
   localparam logic [31:0] CMD_READY        = 32'h0000_000B;
   localparam logic [31:0] CMD_READ_DATA_64 = 32'h0000_0012;

   localparam logic [31:0] STATUS_OK        = 32'h0000_0000;
   localparam logic [31:0] DEFAULT_VERSION  = 32'd2;
   localparam logic [31:0] RESET_TIMEOUT    = 32'd10000;

   localparam logic [31:0] HELLO_MIN_PAYLOAD  = 32'd16;
   localparam logic [31:0] READ_MIN_PAYLOAD   = 32'd12;
   localparam logic [31:0] READ64_MIN_PAYLOAD = 32'd24;
   localparam logic [31:0] END_STATUS_PAYLOAD = 32'd8;
   localparam logic [31:0] DONE_STATUS_PAYLOAD = 32'd4;

   typedef enum logic [2:0] {
      PH_HELLO    = 3'd0,
      PH_SERVE    = 3'd1,
      PH_DONE     = 3'd2,
      PH_FINISHED = 3'd3,
      PH_FAILED   = 3'd4
   } phase_type;

   typedef enum logic [2:0] {
      ACT_HELLO_REPLY = 3'd0,
      ACT_CHUNK       = 3'd1,
      ACT_DONE_REQ    = 3'd2,
      ACT_FINISHED    = 3'd3,
      ACT_FAILED      = 3'd4
   } action_type;

   typedef enum logic [3:0] {
      ERR_BAD_LENGTH     = 4'd0,
      ERR_TIMEOUT        = 4'd1,
      ERR_FIRST_NOT_HELLO = 4'd2,
      ERR_HELLO_SHORT    = 4'd3,
      ERR_READ_SHORT     = 4'd4,
      ERR_READ64_SHORT   = 4'd5,
      ERR_OUT_OF_RANGE   = 4'd6,
      ERR_IMAGE_STATUS   = 4'd7,
      ERR_REPEATED_HELLO = 4'd8,
      ERR_UNEXPECTED_CMD = 4'd9,
      ERR_NOT_DONE_REPLY = 4'd10,
      ERR_DONE_STATUS    = 4'd11
   } error_type;

   typedef enum logic [1:0] {
      EV_TICK    = 2'd0,
      EV_BYTE    = 2'd1,
      EV_FRAME   = 2'd2,
      EV_BAD_LEN = 2'd3
   } event_type;

   typedef logic [CAPTURE_BYTES-1:0][7:0] head_type;

   typedef struct packed {
      event_type   kind;
      logic [31:0] command;
      logic [31:0] value;
      head_type    head;
   } entry_type;

   typedef struct packed {
      logic valid;
      logic full;
   } q_status_type;

   typedef struct packed {
      logic [IMAGE_SIZE_W-1:0] image_size;
      logic [31:0]             hello_timeout;
      logic [31:0]             data_timeout;
   } cfg_type;

   typedef struct packed {
      action_type  action;
      logic [31:0] reply_version;
      logic [31:0] image_number;
      logic [63:0] chunk_offset;
      logic [63:0] chunk_length;
      error_type   error_code;
      logic [31:0] offending_value;
   } result_type;

   function automatic logic [31:0] head_word(head_type head, int unsigned at);
      return {head[at + 3], head[at + 2], head[at + 1], head[at]};
   endfunction

endpackage

// File: hdl/bitfh_front.sv
module bitfh_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic                 event_kind,
   input  logic [7:0]           rx_byte,
   output bitfh_pkg::entry_type entry
);

   logic [bitfh_pkg::HDR_COUNT_W-1:0] hdr_count_ff, hdr_count_in;
   logic [31:0]                       cmd_ff, cmd_in;
   logic [31:0]                       len_ff, len_in;
   logic [bitfh_pkg::SEEN_W-1:0]      seen_ff, seen_in;
   bitfh_pkg::head_type               head_ff, head_in;

   logic [31:0]                  byte_word;
   logic [31:0]                  len_word;
   logic [bitfh_pkg::SEEN_W-1:0] plen;
   logic [bitfh_pkg::SEEN_W-1:0] seen_next;

   always_comb begin
      hdr_count_in  = hdr_count_ff;
      cmd_in        = cmd_ff;
      len_in        = len_ff;
      seen_in       = seen_ff;
      head_in       = head_ff;
      entry.kind    = bitfh_pkg::EV_BYTE;
      entry.command = cmd_ff;
      entry.value   = '0;
      entry.head    = head_ff;
      byte_word = {24'd0, rx_byte} << {hdr_count_ff[1:0], 3'b000};
      len_word  = (hdr_count_ff == bitfh_pkg::HDR_COUNT_W'(4)) ? byte_word
                                                               : (len_ff | byte_word);
      plen      = len_ff[bitfh_pkg::SEEN_W-1:0]
                  - bitfh_pkg::SEEN_W'(bitfh_pkg::HEADER_BYTES);
      seen_next = seen_ff + 1'b1;
      if (event_kind) begin
         entry.kind = bitfh_pkg::EV_TICK;
      end else if (hdr_count_ff < bitfh_pkg::HDR_COUNT_W'(bitfh_pkg::HEADER_BYTES)) begin
         seen_in      = '0;
         hdr_count_in = hdr_count_ff + 1'b1;
         if (!hdr_count_ff[2]) begin
            cmd_in = (hdr_count_ff == '0) ? byte_word : (cmd_ff | byte_word);
         end else begin
            len_in = len_word;
         end
         entry.command = cmd_in;
         if (hdr_count_ff == bitfh_pkg::HDR_COUNT_W'(bitfh_pkg::HEADER_BYTES - 1)) begin
            if (len_word < 32'(bitfh_pkg::HEADER_BYTES) ||
                len_word > 32'(bitfh_pkg::MAX_FRAME_BYTES)) begin
               entry.kind   = bitfh_pkg::EV_BAD_LEN;
               entry.value  = len_word;
               hdr_count_in = '0;
            end else if (len_word == 32'(bitfh_pkg::HEADER_BYTES)) begin
               entry.kind   = bitfh_pkg::EV_FRAME;
               hdr_count_in = '0;
            end
         end
      end else begin
         if (seen_ff < bitfh_pkg::SEEN_W'(bitfh_pkg::CAPTURE_BYTES)) begin
            head_in[seen_ff[bitfh_pkg::CAP_IDX_W-1:0]] = rx_byte;
         end
         entry.head = head_in;
         if (seen_next >= plen) begin
            entry.kind   = bitfh_pkg::EV_FRAME;
            entry.value  = 32'(plen);
            hdr_count_in = '0;
            seen_in      = '0;
         end else begin
            seen_in = seen_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_count_ff <= '0;
         seen_ff      <= '0;
      end else if (accept) begin
         hdr_count_ff <= hdr_count_in;
         seen_ff      <= seen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff  <= cmd_in;
         len_ff  <= len_in;
         head_ff <= head_in;
      end
   end

endmodule

// File: hdl/bitfh_queue.sv
module bitfh_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  bitfh_pkg::entry_type    push_entry,
   input  logic                    pop,
   output bitfh_pkg::entry_type    pop_entry,
   output bitfh_pkg::q_status_type status
);

   bitfh_pkg::entry_type             mem_ff [bitfh_pkg::QUEUE_DEPTH];
   logic [bitfh_pkg::QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [bitfh_pkg::QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [bitfh_pkg::QCNT_W-1:0]     count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == bitfh_pkg::QPTR_W'(bitfh_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                     : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == bitfh_pkg::QPTR_W'(bitfh_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                     : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   assign pop_entry    = mem_ff[rd_ptr_ff];
   assign status.valid = (count_ff != '0);
   assign status.full  = (count_ff == bitfh_pkg::QCNT_W'(bitfh_pkg::QUEUE_DEPTH));

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// File: hdl/bitfh_back.sv
module bitfh_back (
   input  logic                  clock,
   input  logic                  reset,
   input  bitfh_pkg::cfg_type    cfg,
   input  bitfh_pkg::entry_type  entry,
   input  logic                  entry_valid,
   output logic                  pop,
   input  logic                  rsp_stall,
   output bitfh_pkg::result_type rsp,
   output logic                  rsp_valid
);

   bitfh_pkg::phase_type  phase_ff, phase_in;
   logic [31:0]           idle_ff, idle_in;
   bitfh_pkg::result_type rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   bitfh_pkg::result_type res;
   logic                  emit;
   logic                  live;
   logic [31:0]           idle_inc;
   logic [31:0]           limit;
   logic [31:0]           w0, w1, w2, w3, w4, w5;
   logic [63:0]           total;
   logic [63:0]           req_off;
   logic [63:0]           req_len;
   logic                  out_of_range;

   function automatic bitfh_pkg::result_type fail_result(bitfh_pkg::error_type code,
                                                         logic [31:0] val);
      bitfh_pkg::result_type r;
      r                 = '0;
      r.action          = bitfh_pkg::ACT_FAILED;
      r.error_code      = code;
      r.offending_value = val;
      return r;
   endfunction

   function automatic bitfh_pkg::result_type plain_result(bitfh_pkg::action_type act);
      bitfh_pkg::result_type r;
      r        = '0;
      r.action = act;
      return r;
   endfunction

   // decode of the popped request
   always_comb begin
      w0 = bitfh_pkg::head_word(entry.head, 0);
      w1 = bitfh_pkg::head_word(entry.head, 4);
      w2 = bitfh_pkg::head_word(entry.head, 8);
      w3 = bitfh_pkg::head_word(entry.head, 12);
      w4 = bitfh_pkg::head_word(entry.head, 16);
      w5 = bitfh_pkg::head_word(entry.head, 20);
      live     = (phase_ff != bitfh_pkg::PH_FINISHED) && (phase_ff != bitfh_pkg::PH_FAILED);
      idle_inc = (idle_ff == '1) ? idle_ff : idle_ff + 1'b1;
      limit    = (phase_ff == bitfh_pkg::PH_HELLO) ? cfg.hello_timeout : cfg.data_timeout;
      total    = 64'(cfg.image_size);
      if (entry.command == bitfh_pkg::CMD_READ_DATA_64) begin
         req_off = {w3, w2};
         req_len = {w5, w4};
      end else begin
         req_off = {32'd0, w1};
         req_len = {32'd0, w2};
      end
      out_of_range = (req_off > total) || (req_len > total - req_off);
      res  = plain_result(bitfh_pkg::ACT_FAILED);
      emit = 1'b0;
      if (live) begin
         unique case (entry.kind)
            bitfh_pkg::EV_TICK: begin
               if (idle_inc >= limit) begin
                  emit = 1'b1;
                  res  = fail_result(bitfh_pkg::ERR_TIMEOUT, idle_inc);
               end
            end
            bitfh_pkg::EV_BYTE: begin
               emit = 1'b0;
            end
            bitfh_pkg::EV_BAD_LEN: begin
               emit = 1'b1;
               res  = fail_result(bitfh_pkg::ERR_BAD_LENGTH, entry.value);
            end
            bitfh_pkg::EV_FRAME: begin
               emit = 1'b1;
               unique case (phase_ff)
                  bitfh_pkg::PH_HELLO: begin
                     if (entry.command != bitfh_pkg::CMD_HELLO_REQ) begin
                        res = fail_result(bitfh_pkg::ERR_FIRST_NOT_HELLO, entry.command);
                     end else if (entry.value < bitfh_pkg::HELLO_MIN_PAYLOAD) begin
                        res = fail_result(bitfh_pkg::ERR_HELLO_SHORT, entry.value);
                     end else begin
                        res = plain_result(bitfh_pkg::ACT_HELLO_REPLY);
                        res.reply_version = (w0 != '0) ? w0 : bitfh_pkg::DEFAULT_VERSION;
                     end
                  end
                  bitfh_pkg::PH_SERVE: begin
                     priority if (entry.command == bitfh_pkg::CMD_READ_DATA ||
                                  entry.command == bitfh_pkg::CMD_READ_DATA_64) begin
                        if (entry.command == bitfh_pkg::CMD_READ_DATA &&
                            entry.value < bitfh_pkg::READ_MIN_PAYLOAD) begin
                           res = fail_result(bitfh_pkg::ERR_READ_SHORT, entry.value);
                        end else if (entry.command == bitfh_pkg::CMD_READ_DATA_64 &&
                                     entry.value < bitfh_pkg::READ64_MIN_PAYLOAD) begin
                           res = fail_result(bitfh_pkg::ERR_READ64_SHORT, entry.value);
                        end else if (out_of_range) begin
                           res = fail_result(bitfh_pkg::ERR_OUT_OF_RANGE, req_len[31:0]);
                        end else begin
                           res              = plain_result(bitfh_pkg::ACT_CHUNK);
                           res.image_number = w0;
                           res.chunk_offset = req_off;
                           res.chunk_length = req_len;
                        end
                     end else if (entry.command == bitfh_pkg::CMD_END_IMAGE) begin
                        if (entry.value >= bitfh_pkg::END_STATUS_PAYLOAD &&
                            w1 != bitfh_pkg::STATUS_OK) begin
                           res = fail_result(bitfh_pkg::ERR_IMAGE_STATUS, w1);
                        end else begin
                           res = plain_result(bitfh_pkg::ACT_DONE_REQ);
                        end
                     end else if (entry.command == bitfh_pkg::CMD_DONE_RSP ||
                                  entry.command == bitfh_pkg::CMD_READY) begin
                        res = plain_result(bitfh_pkg::ACT_FINISHED);
                     end else if (entry.command == bitfh_pkg::CMD_HELLO_REQ) begin
                        res = fail_result(bitfh_pkg::ERR_REPEATED_HELLO, entry.command);
                     end else begin
                        res = fail_result(bitfh_pkg::ERR_UNEXPECTED_CMD, entry.command);
                     end
                  end
                  bitfh_pkg::PH_DONE: begin
                     if (entry.command != bitfh_pkg::CMD_DONE_RSP) begin
                        res = fail_result(bitfh_pkg::ERR_NOT_DONE_REPLY, entry.command);
                     end else if (entry.value >= bitfh_pkg::DONE_STATUS_PAYLOAD &&
                                  w0 != bitfh_pkg::STATUS_OK) begin
                        res = fail_result(bitfh_pkg::ERR_DONE_STATUS, w0);
                     end else begin
                        res = plain_result(bitfh_pkg::ACT_FINISHED);
                     end
                  end
                  default: begin
                     emit = 1'b0;
                  end
               endcase
            end
         endcase
      end
   end

   // next state
   always_comb begin
      phase_in = phase_ff;
      idle_in  = idle_ff;
      if (pop && live) begin
         idle_in = (entry.kind == bitfh_pkg::EV_TICK) ? idle_inc : '0;
         if (emit) begin
            unique case (res.action)
               bitfh_pkg::ACT_HELLO_REPLY: phase_in = bitfh_pkg::PH_SERVE;
               bitfh_pkg::ACT_CHUNK:       phase_in = phase_ff;
               bitfh_pkg::ACT_DONE_REQ:    phase_in = bitfh_pkg::PH_DONE;
               bitfh_pkg::ACT_FINISHED:    phase_in = bitfh_pkg::PH_FINISHED;
               bitfh_pkg::ACT_FAILED:      phase_in = bitfh_pkg::PH_FAILED;
               default:                    phase_in = phase_ff;
            endcase
         end
      end
   end

   // outputs
   always_comb begin
      pop          = entry_valid && (!rsp_valid_ff || !rsp_stall);
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (pop && emit) begin
         rsp_in       = res;
         rsp_valid_in = 1'b1;
      end
   end

   assign rsp       = rsp_ff;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= bitfh_pkg::PH_HELLO;
         idle_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         idle_ff      <= idle_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

endmodule

// File: hdl/boot_image_transfer_host_fsm_unit.sv
// Host side of the boot image transfer handshake. Each request is either a received
// byte or one timer tick; bytes are reassembled into little-endian frames (command,
// total length, payload) and the protocol engine answers with a hello reply, an image
// chunk descriptor, a done request, a finished mark or a failure with its code and
// offending word, at most one response per request. One request is taken every clock
// cycle unless req_stall is high: the frame assembler builds each entry combinationally
// and a two-entry queue parts it from the protocol engine, whose single output register
// holds a response until taken. A request waits in the queue, its response in the output
// register; req_stall rises only while the queue is full, that is while rsp_stall holds
// the output register. Write configuration only while idle; the block does not check.
`include "boot_image_transfer_host_fsm_unit_defines.svh"

module boot_image_transfer_host_fsm_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_event_kind,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_action,
   output logic [31:0] rsp_reply_version,
   output logic [31:0] rsp_image_number,
   output logic [63:0] rsp_chunk_offset,
   output logic [63:0] rsp_chunk_length,
   output logic [3:0]  rsp_error_code,
   output logic [31:0] rsp_offending_value,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);

   logic [bitfh_pkg::IMAGE_SIZE_W-1:0] image_size_ff;
   logic [31:0]                        hello_timeout_ff;
   logic [31:0]                        data_timeout_ff;

   bitfh_pkg::cfg_type      cfg;
   bitfh_pkg::entry_type    push_entry;
   bitfh_pkg::entry_type    pop_entry;
   bitfh_pkg::q_status_type q_status;
   bitfh_pkg::result_type   rsp;
   logic                    accept;
   logic                    pop;

   assign csr_ready = 1'b1;
   assign accept    = req_valid && !q_status.full;
   assign req_stall = q_status.full;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_size_ff    <= '0;
         hello_timeout_ff <= bitfh_pkg::RESET_TIMEOUT;
         data_timeout_ff  <= bitfh_pkg::RESET_TIMEOUT;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            bitfh_pkg::CSR_IMAGE_SIZE: begin
               image_size_ff <= csr_data[bitfh_pkg::IMAGE_SIZE_W-1:0];
            end
            bitfh_pkg::CSR_HELLO_TIMEOUT: begin
               hello_timeout_ff <= csr_data;
            end
            bitfh_pkg::CSR_DATA_TIMEOUT: begin
               data_timeout_ff <= csr_data;
            end
            default: begin
            end
         endcase
      end
   end

   assign cfg.image_size    = image_size_ff;
   assign cfg.hello_timeout = hello_timeout_ff;
   assign cfg.data_timeout  = data_timeout_ff;

   bitfh_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .event_kind (req_event_kind),
      .rx_byte    (req_rx_byte),
      .entry      (push_entry)
   );

   bitfh_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (accept),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .status     (q_status)
   );

   bitfh_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .entry       (pop_entry),
      .entry_valid (q_status.valid),
      .pop         (pop),
      .rsp_stall   (rsp_stall),
      .rsp         (rsp),
      .rsp_valid   (rsp_valid)
   );

   assign rsp_action          = rsp.action;
   assign rsp_reply_version   = rsp.reply_version;
   assign rsp_image_number    = rsp.image_number;
   assign rsp_chunk_offset    = rsp.chunk_offset;
   assign rsp_chunk_length    = rsp.chunk_length;
   assign rsp_error_code      = rsp.error_code;
   assign rsp_offending_value = rsp.offending_value;

   // nothing follows a delivered terminal response
   `BITFH_ASSERT_NEXT(a_terminal_last, clock, reset, rsp_valid && !rsp_stall && (rsp_action == bitfh_pkg::ACT_FAILED || rsp_action == bitfh_pkg::ACT_FINISHED), !rsp_valid)
   // a served chunk lies inside the image
   `BITFH_ASSERT_IMPL(a_chunk_in_range, clock, reset, rsp_valid && rsp_action == bitfh_pkg::ACT_CHUNK, rsp_chunk_offset <= 64'(image_size_ff) && rsp_chunk_length <= 64'(image_size_ff) - rsp_chunk_offset)
   // hello reply never carries version zero
   `BITFH_ASSERT_IMPL(a_hello_version, clock, reset, rsp_valid && rsp_action == bitfh_pkg::ACT_HELLO_REPLY, rsp_reply_version != 32'd0)

endmodule
